### sv/itt_pkg.sv
// Types and codes shared by the indexed priority task table.
`timescale 1ns / 1ps
package itt_pkg;

	localparam int ID_W   = 10;
	localparam int USER_W = 17;
	localparam int RANK_W = 30;

	typedef enum logic [1:0] {
		MODE_ADD    = 2'd0,
		MODE_EDIT   = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_EXEC   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_DONE   = 2'd0,
		STAT_EMPTY  = 2'd1,
		STAT_ABSENT = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_SCAN_END,
		ST_FINISH,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic              present;
		logic [USER_W-1:0] owner;
		logic [RANK_W-1:0] rank;
	} entry_t;

	typedef struct packed {
		status_t           status;
		logic [USER_W-1:0] user;
	} result_t;

endpackage

### sv/itt_mem.sv
// Task table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module itt_mem
	import itt_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int IDX_W = 10
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  entry_t           wdata,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr,
	output entry_t           rdata
);

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/itt_ctrl.sv
// Sequencer for table operations: clearing pass, read-modify-write and the top scan.
`timescale 1ns / 1ps
module itt_ctrl
	import itt_pkg::*;
#(
	parameter int MAX_TASKS = 1024,
	parameter int IDX_W     = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mode_t             in_mode,
	input  logic [ID_W-1:0]   in_task_id,
	input  logic [USER_W-1:0] in_user,
	input  logic [RANK_W-1:0] in_prio,
	output logic              res_valid,
	input  logic              res_ready,
	output result_t           res,
	output logic              mem_we,
	output logic [IDX_W-1:0]  mem_waddr,
	output entry_t            mem_wdata,
	output logic              mem_re,
	output logic [IDX_W-1:0]  mem_raddr,
	input  entry_t            mem_rdata
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  cnt_q;
	mode_t             mode_q;
	logic [IDX_W-1:0]  id_q;
	logic [RANK_W-1:0] prio_q;
	logic              scan_vld_s1;
	logic [IDX_W-1:0]  scan_idx_s1;
	logic              best_found_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [RANK_W-1:0] best_rank_q;
	logic [USER_W-1:0] best_owner_q;
	result_t           res_q;

	logic              accept;
	logic              in_range;
	logic [IDX_W-1:0]  in_idx;
	logic              cnt_last;

	assign accept   = in_valid && in_ready;
	assign in_range = 32'(in_task_id) < MAX_TASKS;
	assign in_idx   = IDX_W'(in_task_id);
	assign cnt_last = cnt_q == LAST_IDX;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (cnt_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					case (in_mode)
						MODE_EXEC: state_d = ST_SCAN;
						MODE_ADD:  state_d = ST_RESP;
						default:   state_d = in_range ? ST_CHECK : ST_RESP;
					endcase
				end
			end
			ST_CHECK:    state_d = ST_RESP;
			ST_SCAN: begin
				if (cnt_last) state_d = ST_SCAN_END;
			end
			ST_SCAN_END: state_d = ST_FINISH;
			ST_FINISH:   state_d = ST_RESP;
			ST_RESP: begin
				if (res_ready) state_d = ST_IDLE;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && in_range && in_mode == MODE_ADD) begin
					mem_we    = 1'b1;
					mem_waddr = in_idx;
					mem_wdata = '{present: 1'b1, owner: in_user, rank: in_prio};
				end
				if (in_valid && in_range && (in_mode == MODE_EDIT || in_mode == MODE_REMOVE))
				begin
					mem_re    = 1'b1;
					mem_raddr = in_idx;
				end
			end
			ST_CHECK: begin
				if (mem_rdata.present) begin
					mem_we    = 1'b1;
					mem_waddr = id_q;
					if (mode_q == MODE_EDIT) begin
						mem_wdata = '{present: 1'b1, owner: mem_rdata.owner, rank: prio_q};
					end else begin
						mem_wdata = '{present: 1'b0, owner: mem_rdata.owner,
							rank: mem_rdata.rank};
					end
				end
			end
			ST_SCAN: begin
				mem_re    = 1'b1;
				mem_raddr = cnt_q;
			end
			ST_FINISH: begin
				if (best_found_q) begin
					mem_we    = 1'b1;
					mem_waddr = best_idx_q;
					mem_wdata = '{present: 1'b0, owner: best_owner_q, rank: best_rank_q};
				end
			end
			ST_RESP: begin
				res_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			cnt_q        <= '0;
			scan_vld_s1  <= 1'b0;
			best_found_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			scan_vld_s1 <= state_q == ST_SCAN;
			if (state_q == ST_CLEAR || state_q == ST_SCAN) begin
				cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
			end
			if (accept) begin
				best_found_q <= 1'b0;
			end else if (scan_vld_s1 && mem_rdata.present &&
				(!best_found_q || mem_rdata.rank >= best_rank_q)) begin
				best_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_idx_s1 <= cnt_q;
		if (accept) begin
			mode_q <= in_mode;
			id_q   <= in_idx;
			prio_q <= in_prio;
			res_q  <= '{status: (in_range ? STAT_DONE : STAT_ABSENT), user: '0};
		end
		if (scan_vld_s1 && mem_rdata.present &&
			(!best_found_q || mem_rdata.rank >= best_rank_q)) begin
			best_idx_q   <= scan_idx_s1;
			best_rank_q  <= mem_rdata.rank;
			best_owner_q <= mem_rdata.owner;
		end
		if (state_q == ST_CHECK) begin
			res_q <= '{status: (mem_rdata.present ? STAT_DONE : STAT_ABSENT), user: '0};
		end
		if (state_q == ST_FINISH) begin
			if (best_found_q) begin
				res_q <= '{status: STAT_DONE, user: best_owner_q};
			end else begin
				res_q <= '{status: STAT_EMPTY, user: '0};
			end
		end
	end

	assign res = res_q;

`ifndef SYNTH
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !mem_we)
		else $error("table written during top scan");

	a_check_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> $past(mem_re))
		else $error("entry check without a preceding read");

	a_empty_only_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == STAT_EMPTY) |-> (mode_q == MODE_EXEC && !best_found_q))
		else $error("empty status outside a failed execute");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res)))
		else $error("pending result changed before it was taken");
`endif

endmodule

### sv/indexed_priority_task_table.sv
// Top level of the indexed priority task table with its output register.
//
// Usage: each item on the slave stream carries one operation in s_tuser (add,
// edit priority, remove, execute top) and the task id, owner and priority in
// s_tdata. Every item yields exactly one result item on the master stream:
// a status in m_tuser (done, table empty, task absent) and, for a successful
// execute, the owner of the removed task in m_tdata.
// Items are handled one at a time. An add is written as it is accepted and an
// out-of-range id gets its status at once; edit and remove read the entry,
// then write it back; execute top is set by the scan that reads one table
// entry per cycle through the single read port, then removes the task found.
// The controller returns to idle at the edge at which a result enters the
// output register, and takes the next item from there.
// After reset a clearing pass empties every table entry; no item is
// accepted until it ends. When the receiver stalls, the result waits in the
// output register; one further item is accepted and worked on, and its result
// waits until the register is free.
`timescale 1ns / 1ps
module indexed_priority_task_table
	import itt_pkg::*;
#(
	parameter int MAX_TASKS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // task_id[9:0], user_id[26:10], priority_req[56:27]
	input  logic [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // top_user[16:0]
	output logic [1:0]  m_tuser    // status[1:0]
);

	localparam int IDX_W = $clog2(MAX_TASKS);

	logic              res_valid;
	logic              res_ready;
	result_t           res;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	entry_t            mem_wdata;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_raddr;
	entry_t            mem_rdata;

	logic              out_valid_q;
	logic [USER_W-1:0] out_user_q;
	status_t           out_status_q;

	itt_ctrl #(
		.MAX_TASKS (MAX_TASKS),
		.IDX_W     (IDX_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_mode    (mode_t'(s_tuser)),
		.in_task_id (s_tdata[9:0]),
		.in_user    (s_tdata[26:10]),
		.in_prio    (s_tdata[56:27]),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	itt_mem #(
		.DEPTH (MAX_TASKS),
		.IDX_W (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_user_q   <= res.user;
			out_status_q <= res.status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_user_q};
	assign m_tuser  = out_status_q;

endmodule
